### rtl/adc_supply_and_battery_monitor_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the supply and battery monitor
// Shared concurrent-assertion wrappers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ADC_SUPPLY_AND_BATTERY_MONITOR_CORE_DEFINES_SVH
`define ADC_SUPPLY_AND_BATTERY_MONITOR_CORE_DEFINES_SVH

// same-cycle implication
`define ASBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/asbm_pkg.sv
// ---------------------------------------------------------------------------
// asbm_pkg
// Constants, register codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package asbm_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int VREF_W       = 12;
  localparam int MV_W         = 16;
  localparam int CNT_W        = 8;
  localparam int POS_W        = 9;
  localparam int CFG_AW       = 2;
  localparam int CFG_DW       = 12;

  localparam logic [CFG_AW-1:0] CFG_DISCARD = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_AVERAGE = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_VREF    = 2'd2;

  localparam logic [CNT_W-1:0]  DISCARD_RST = 8'd8;
  localparam logic [CNT_W-1:0]  AVERAGE_RST = 8'd8;
  localparam logic [VREF_W-1:0] VREF_RST    = 12'd1100;

  localparam logic [MV_W-1:0]   MV_SAT      = 16'hFFFF;

  typedef struct packed {
    logic accept;       // input request taken this cycle
    logic div_start;    // launch the divider
    logic div_vcc;      // 0: sum / count, 1: (vref << ADC_BITS) / average
    logic avg_load;     // capture the average from the divider
    logic mul_load;     // capture average * stored Vcc
    logic result_load;  // load the output register
  } asbm_cmd_t;

  typedef struct packed {
    logic run_end;      // the offered sample closes the open run
    logic avg_zero;
    logic run_mode;
    logic div_done;
    logic out_full;     // output register busy this cycle
  } asbm_stat_t;

endpackage

### rtl/asbm_div.sv
// ---------------------------------------------------------------------------
// asbm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module asbm_div #(
  parameter int NW = 22,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);
  localparam logic [CW-1:0] STEPS = CW'(NW);

  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt;

  logic [DW:0]   shifted;
  logic [DW+1:0] diff;
  logic          ge;

  always_comb begin
    shifted = {rem, quo[NW-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    ge      = !diff[DW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= STEPS;
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - CW'(1);
      done <= (cnt == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (cnt != '0) begin
      rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule

### rtl/asbm_datapath.sv
// ---------------------------------------------------------------------------
// asbm_datapath
// Configuration, run accumulation, divider, multiplier and output register.
// ---------------------------------------------------------------------------
module asbm_datapath
  import asbm_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  input  logic [ADC_BITS-1:0] sample,
  input  logic                mode,
  input  logic                start_req,
  input  logic                out_ready,
  input  asbm_cmd_t           cmd,
  output asbm_stat_t          stat,
  output logic                out_valid,
  output logic [MV_W-1:0]     out_mv,
  output logic                out_mode,
  output logic                out_err
);

  localparam int SW = ADC_BITS + CNT_W;   // run sum
  localparam int NW = ADC_BITS + VREF_W;  // divider numerator
  localparam int DW = ADC_BITS;           // divider denominator
  localparam int PW = ADC_BITS + MV_W;    // product

  logic [CNT_W-1:0]    discard_count;
  logic [CNT_W-1:0]    average_count;
  logic [VREF_W-1:0]   vref_mv;

  logic                run_active;
  logic [POS_W-1:0]    run_position;
  logic [SW-1:0]       sample_sum;
  logic                run_mode;
  logic [MV_W-1:0]     stored_vcc_mv;
  logic [ADC_BITS-1:0] avg;
  logic [PW-1:0]       prod;

  logic [CNT_W-1:0]    cnt_eff;
  logic                active_eff;
  logic [POS_W-1:0]    pos_eff;
  logic [SW-1:0]       sum_eff;
  logic [POS_W-1:0]    pos_next;
  logic [POS_W-1:0]    end_pos;

  logic [NW-1:0]       div_num;
  logic [DW-1:0]       div_den;
  logic [NW-1:0]       div_quo;
  logic                div_done;

  logic [MV_W-1:0]     mv_next;
  logic                err_next;

  assign cnt_eff = (average_count == '0) ? CNT_W'(1) : average_count;

  always_comb begin
    active_eff = start_req | run_active;
    pos_eff    = start_req ? '0 : run_position;
    sum_eff    = start_req ? '0 : sample_sum;
    pos_next   = pos_eff + POS_W'(1);
    end_pos    = {1'b0, discard_count} + {1'b0, cnt_eff};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      discard_count <= DISCARD_RST;
      average_count <= AVERAGE_RST;
      vref_mv       <= VREF_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DISCARD: discard_count <= cfg_wdata[CNT_W-1:0];
        CFG_AVERAGE: average_count <= cfg_wdata[CNT_W-1:0];
        CFG_VREF:    vref_mv       <= cfg_wdata[VREF_W-1:0];
        default:     ;
      endcase
    end
  end

  // run bookkeeping; a start request abandons whatever run is open
  always_ff @(posedge clk) begin
    if (rst) begin
      run_active   <= 1'b0;
      run_position <= '0;
      sample_sum   <= '0;
      run_mode     <= 1'b0;
    end else if (cmd.accept && active_eff) begin
      if (start_req) begin
        run_mode <= mode;
      end
      run_position <= pos_next;
      sample_sum   <= (pos_eff >= {1'b0, discard_count}) ?
                      sum_eff + SW'(sample) : sum_eff;
      run_active   <= (pos_next != end_pos);
    end
  end

  assign div_num = cmd.div_vcc ? {vref_mv, {ADC_BITS{1'b0}}} : NW'(sample_sum);
  assign div_den = cmd.div_vcc ? avg : DW'(cnt_eff);

  asbm_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .done (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.avg_load) begin
      avg <= div_quo[ADC_BITS-1:0];
    end
    if (cmd.mul_load) begin
      prod <= PW'(avg) * PW'(stored_vcc_mv);
    end
  end

  always_comb begin
    if (avg == '0) begin
      mv_next  = MV_SAT;
      err_next = 1'b1;
    end else if (!run_mode) begin
      if (div_quo[NW-1:MV_W] != '0) begin
        mv_next  = MV_SAT;
        err_next = 1'b1;
      end else begin
        mv_next  = div_quo[MV_W-1:0];
        err_next = 1'b0;
      end
    end else begin
      mv_next  = prod[PW-1:ADC_BITS];
      err_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_vcc_mv <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.result_load) begin
        out_valid <= 1'b1;
        if (!run_mode) begin
          stored_vcc_mv <= mv_next;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_mv   <= mv_next;
      out_mode <= run_mode;
      out_err  <= err_next;
    end
  end

  always_comb begin
    stat.run_end  = active_eff && (pos_next == end_pos);
    stat.avg_zero = (avg == '0);
    stat.run_mode = run_mode;
    stat.div_done = div_done;
    stat.out_full = out_valid && !out_ready;
  end

endmodule

### rtl/asbm_ctrl.sv
// ---------------------------------------------------------------------------
// asbm_ctrl
// Sequencer: takes samples, then runs the end-of-run arithmetic.
// ---------------------------------------------------------------------------
module asbm_ctrl
  import asbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  asbm_stat_t stat,
  output asbm_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG_START,
    S_AVG_WAIT,
    S_OP,
    S_VCC_WAIT,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && stat.run_end) begin
          state_next = S_AVG_START;
        end
      end
      S_AVG_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (stat.div_done) begin
          cmd.avg_load = 1'b1;
          state_next   = S_OP;
        end
      end
      S_OP: begin
        if (stat.avg_zero) begin
          state_next = S_DONE;
        end else if (!stat.run_mode) begin
          cmd.div_start = 1'b1;
          cmd.div_vcc   = 1'b1;
          state_next    = S_VCC_WAIT;
        end else begin
          cmd.mul_load = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_VCC_WAIT: begin
        if (stat.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register frees up
        if (!stat.out_full) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/adc_supply_and_battery_monitor_core.sv
// ---------------------------------------------------------------------------
// adc_supply_and_battery_monitor_core
// Averages runs of ADC samples and converts them to Vcc or battery millivolts.
// ---------------------------------------------------------------------------
// A request with tuser[1] (start) set opens a run and latches tuser[0] (mode).
// The first discard_count samples of a run are dropped and the next
// average_count are summed; the request that closes the run yields one result.
// Mode 0 gives Vcc = 2^ADC_BITS * vref_mv / average and keeps it; mode 1 gives
// average * stored Vcc / 2^ADC_BITS. A zero average or an overflow returns
// 65535 with the error flag. Samples inside a run are taken back to back. On
// the closing sample the bit-serial divider computes first the average and
// then, in mode 0, the Vcc quotient; mode 1 instead multiplies the average by
// the stored Vcc, and a zero average skips both. The result then waits while
// the output register still holds a result that is not being taken; no
// request is taken meanwhile. A finished result sits in the output register
// while new samples are taken.
// ---------------------------------------------------------------------------
`include "adc_supply_and_battery_monitor_core_defines.svh"

module adc_supply_and_battery_monitor_core
  import asbm_pkg::*;
#(
  parameter  int ADC_BITS = ADC_BITS_DEF,
  localparam int IN_TDW   = ((ADC_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_TDW-1:0] s_axis_tdata,   // sample
  input  logic [1:0]        s_axis_tuser,   // mode, start_req
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [MV_W-1:0]   m_axis_tdata,   // millivolts
  output logic [1:0]        m_axis_tuser    // result_mode, error
);

  asbm_cmd_t  cmd;
  asbm_stat_t stat;
  logic       out_mode;
  logic       out_err;

  asbm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  asbm_datapath #(
    .ADC_BITS(ADC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .sample   (s_axis_tdata[ADC_BITS-1:0]),
    .mode     (s_axis_tuser[0]),
    .start_req(s_axis_tuser[1]),
    .out_ready(m_axis_tready),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(m_axis_tvalid),
    .out_mv   (m_axis_tdata),
    .out_mode (out_mode),
    .out_err  (out_err)
  );

  assign m_axis_tuser = {out_err, out_mode};

  `ASBM_ASSERT_NXT(a_close_blocks_input, cmd.accept && stat.run_end, !s_axis_tready,
                   "input still ready after the closing sample of a run")
  `ASBM_ASSERT_IMP(a_result_from_load, $rose(m_axis_tvalid), $past(cmd.result_load),
                   "output valid rose without a result load")

endmodule
